### rtl/dau_pkg.sv
// Shared types, widths and constants of the dihedral angle unit.
package dau_pkg;

  localparam int COORD_BITS = 24;
  localparam int IDX_W      = 10;
  localparam int ATOM_DEPTH = 1024;
  localparam int ANGLE_W    = 17;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = 1;

  // Datapath widths of the back end.
  localparam int DIFF_W    = COORD_BITS + 1;
  localparam int NORM_W    = 2 * DIFF_W + 1;
  localparam int RED_W     = 16;
  localparam int PQ_W      = 2 * RED_W + 1;
  localparam int MUL_W     = 34;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int ACC_W     = 80;
  localparam int SQ_W      = 64;
  localparam int ROOT_W    = 32;
  localparam int REM_W     = ROOT_W + 2;
  localparam int XD_W      = 34;
  localparam int CV_W      = 36;
  localparam int Z_W       = 26;
  localparam int ATAN_W    = 22;
  localparam int DIR_SPLIT = 26;
  localparam int CORDIC_STEPS = 20;

  localparam int DEG90_Z      = 5898240;
  localparam int DEG180_Z     = 11796480;
  localparam int FULL_TURN_Q8 = 92160;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } atom_t;

  typedef struct packed {
    atom_t a;
    atom_t b;
    atom_t c;
    atom_t d;
  } query_t;

  typedef struct packed {
    logic                         cmd;
    logic [IDX_W-1:0]             atom_slot;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
    logic [IDX_W-1:0]             first_atom;
    logic [IDX_W-1:0]             second_atom;
    logic [IDX_W-1:0]             third_atom;
    logic [IDX_W-1:0]             fourth_atom;
  } req_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle_deg;
    logic               degenerate;
  } rsp_t;

  // atan(2^-i) in degrees scaled by 2^16, rounded to nearest.
  function automatic logic [ATAN_W-1:0] atan_q16(input logic [4:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/dau_front.sv
// Front end: takes requests, keeps the atom table and gathers the four atoms of a query.
module dau_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  dau_pkg::req_t    req,
  output logic             q_push,
  output dau_pkg::query_t  q_entry,
  input  logic             q_full
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_READ = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t state;
  logic [2:0] rd_cnt;
  logic [dau_pkg::IDX_W-1:0] idx [4];
  logic [dau_pkg::IDX_W-1:0] rd_addr;
  dau_pkg::atom_t mem [dau_pkg::ATOM_DEPTH];
  dau_pkg::atom_t rd_data;
  dau_pkg::query_t entry;
  logic accept;

  assign req_ready = (state == F_IDLE);
  assign accept    = req_valid && req_ready;
  assign q_push    = (state == F_PUSH) && !q_full;
  assign q_entry   = entry;
  assign rd_addr   = idx[rd_cnt[1:0]];

  // Table write on a load, one registered read per cycle for queries.
  always_ff @(posedge clk) begin
    if (accept && req.cmd == dau_pkg::CMD_LOAD) begin
      mem[req.atom_slot] <= '{x: req.coord_x, y: req.coord_y, z: req.coord_z};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= F_IDLE;
      rd_cnt <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept && req.cmd == dau_pkg::CMD_QUERY) begin
            rd_cnt <= '0;
            state  <= F_READ;
          end
        end
        F_READ: begin
          rd_cnt <= rd_cnt + 3'd1;
          if (rd_cnt == 3'd4) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req.cmd == dau_pkg::CMD_QUERY) begin
      idx[0] <= req.first_atom;
      idx[1] <= req.second_atom;
      idx[2] <= req.third_atom;
      idx[3] <= req.fourth_atom;
    end
    if (state == F_READ) begin
      case (rd_cnt)
        3'd1:    entry.a <= rd_data;
        3'd2:    entry.b <= rd_data;
        3'd3:    entry.c <= rd_data;
        3'd4:    entry.d <= rd_data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/dau_queue.sv
// Short queue of gathered queries between the front and back ends.
module dau_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dau_pkg::query_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output dau_pkg::query_t pop_data
);

  dau_pkg::query_t entries [dau_pkg::QDEPTH];
  logic [dau_pkg::QPTR_W-1:0] wr_ptr;
  logic [dau_pkg::QPTR_W-1:0] rd_ptr;
  logic [dau_pkg::QPTR_W:0]   count;

  assign full     = (count == (dau_pkg::QPTR_W + 1)'(dau_pkg::QDEPTH));
  assign valid    = (count != '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue read while empty");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (dau_pkg::QPTR_W + 1)'(dau_pkg::QDEPTH))
    else $error("queue count beyond its depth");
`endif

endmodule

### rtl/dau_back.sv
// Back end: normals, direction sign, reduction, square root and CORDIC arctangent.
module dau_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  dau_pkg::query_t q_data,
  output logic            q_pop,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output dau_pkg::rsp_t   rsp
);

  localparam int DIFF_W = dau_pkg::DIFF_W;
  localparam int NORM_W = dau_pkg::NORM_W;
  localparam int RED_W  = dau_pkg::RED_W;
  localparam int PQ_W   = dau_pkg::PQ_W;
  localparam int MUL_W  = dau_pkg::MUL_W;
  localparam int ACC_W  = dau_pkg::ACC_W;
  localparam int SQ_W   = dau_pkg::SQ_W;
  localparam int ROOT_W = dau_pkg::ROOT_W;
  localparam int REM_W  = dau_pkg::REM_W;
  localparam int XD_W   = dau_pkg::XD_W;
  localparam int CV_W   = dau_pkg::CV_W;
  localparam int Z_W    = dau_pkg::Z_W;
  localparam int SPL    = dau_pkg::DIR_SPLIT;
  localparam int ANG_W  = dau_pkg::ANGLE_W;

  localparam logic [4:0] NORM_END = 5'd12;
  localparam logic [4:0] DIR_END  = 5'd18;
  localparam logic [4:0] PQ_END   = 5'd24;
  localparam logic [4:0] DOT_END  = 5'd30;
  localparam logic [4:0] SQRT_LAST = 5'(ROOT_W - 1);
  localparam logic [4:0] CORD_LAST = 5'(dau_pkg::CORDIC_STEPS - 1);

  localparam logic signed [Z_W-1:0] Z90  = Z_W'(dau_pkg::DEG90_Z);
  localparam logic signed [Z_W-1:0] Z180 = Z_W'(dau_pkg::DEG180_Z);
  localparam logic [ANG_W-1:0] FULL_TURN = ANG_W'(dau_pkg::FULL_TURN_Q8);

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [NORM_W-1:0] norm_t;
  typedef logic signed [PQ_W-1:0]   pq_t;
  typedef logic signed [MUL_W-1:0]  mop_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_N1X, DST_N1Y, DST_N1Z, DST_N2X, DST_N2Y, DST_N2Z,
    DST_PQX, DST_PQY, DST_PQZ, DST_SQ, DST_XD, DST_DIR
  } dst_t;

  typedef struct packed {
    logic vld;
    logic clr;
    logic neg;
    logic sh;
    dst_t dst;
  } mac_ctl_t;

  typedef enum logic [10:0] {
    B_IDLE  = 11'b00000000001,
    B_NORM  = 11'b00000000010,
    B_DIR   = 11'b00000000100,
    B_MAG   = 11'b00000001000,
    B_RED   = 11'b00000010000,
    B_PQ    = 11'b00000100000,
    B_DOT   = 11'b00001000000,
    B_SQRT  = 11'b00010000000,
    B_SETUP = 11'b00100000000,
    B_CORD  = 11'b01000000000,
    B_DONE  = 11'b10000000000
  } bstate_t;

  bstate_t state;
  logic [4:0] step;
  logic [4:0] iter;
  diff_t ba [3];
  diff_t ca [3];
  diff_t cb [3];
  diff_t db [3];
  diff_t dc [3];
  norm_t n1 [3];
  norm_t n2 [3];
  pq_t   pq [3];
  logic [NORM_W-1:0] m1;
  logic [NORM_W-1:0] m2;
  logic [SQ_W-1:0] sq;
  logic signed [XD_W-1:0] xd;
  logic dir_neg;
  logic deg;
  logic [ROOT_W-1:0] root;
  logic [REM_W-1:0] rem;
  logic signed [CV_W-1:0] cx;
  logic signed [CV_W-1:0] cy;
  logic signed [Z_W-1:0] cz;
  logic signed [dau_pkg::PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] base;
  mac_ctl_t ctl;
  mac_ctl_t op_c;
  mop_t op_a;
  mop_t op_b;
  logic [4:0] phase_end;
  logic in_mul;
  logic issue;
  logic shift1;
  logic shift2;
  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic root_ge;
  logic signed [CV_W-1:0] xs;
  logic signed [CV_W-1:0] ys;
  logic signed [Z_W-1:0] at_step;
  logic [Z_W-3:0] zc;
  logic [Z_W-2:0] zr;
  logic [ANG_W-1:0] rnd;
  logic [ANG_W-1:0] angle;
  logic out_free;

  function automatic diff_t dsub(input dau_pkg::coord_t p, input dau_pkg::coord_t m);
    return diff_t'(p) - diff_t'(m);
  endfunction

  function automatic logic [NORM_W-1:0] nmag(input norm_t v);
    return v[NORM_W-1] ? NORM_W'(-v) : NORM_W'(v);
  endfunction

  function automatic mop_t red(input norm_t v);
    return MUL_W'($signed(v[RED_W-1:0]));
  endfunction

  function automatic mop_t hi_part(input norm_t v);
    return MUL_W'($signed(v[NORM_W-1:SPL]));
  endfunction

  function automatic mop_t lo_part(input norm_t v);
    return MUL_W'({1'b0, v[SPL-1:0]});
  endfunction

  assign q_pop    = (state == B_IDLE) && q_valid;
  assign out_free = !rsp_valid || rsp_ready;

  always_comb begin
    case (state)
      B_NORM:  phase_end = NORM_END;
      B_DIR:   phase_end = DIR_END;
      B_PQ:    phase_end = PQ_END;
      default: phase_end = DOT_END;
    endcase
  end

  assign in_mul = (state == B_NORM) || (state == B_DIR) || (state == B_PQ) ||
                  (state == B_DOT);
  assign issue  = in_mul && (step != phase_end);

  // Multiply schedule: products of one multiplier, summed in the accumulator.
  always_comb begin
    op_a = '0;
    op_b = '0;
    op_c = '0;
    case (step)
      5'd0:  begin op_a = MUL_W'(ba[1]); op_b = MUL_W'(ca[2]); op_c.clr = 1'b1; end
      5'd1:  begin op_a = MUL_W'(ba[2]); op_b = MUL_W'(ca[1]); op_c.neg = 1'b1;
                   op_c.dst = DST_N1X; end
      5'd2:  begin op_a = MUL_W'(ba[2]); op_b = MUL_W'(ca[0]); op_c.clr = 1'b1; end
      5'd3:  begin op_a = MUL_W'(ba[0]); op_b = MUL_W'(ca[2]); op_c.neg = 1'b1;
                   op_c.dst = DST_N1Y; end
      5'd4:  begin op_a = MUL_W'(ba[0]); op_b = MUL_W'(ca[1]); op_c.clr = 1'b1; end
      5'd5:  begin op_a = MUL_W'(ba[1]); op_b = MUL_W'(ca[0]); op_c.neg = 1'b1;
                   op_c.dst = DST_N1Z; end
      5'd6:  begin op_a = MUL_W'(cb[1]); op_b = MUL_W'(db[2]); op_c.clr = 1'b1; end
      5'd7:  begin op_a = MUL_W'(cb[2]); op_b = MUL_W'(db[1]); op_c.neg = 1'b1;
                   op_c.dst = DST_N2X; end
      5'd8:  begin op_a = MUL_W'(cb[2]); op_b = MUL_W'(db[0]); op_c.clr = 1'b1; end
      5'd9:  begin op_a = MUL_W'(cb[0]); op_b = MUL_W'(db[2]); op_c.neg = 1'b1;
                   op_c.dst = DST_N2Y; end
      5'd10: begin op_a = MUL_W'(cb[0]); op_b = MUL_W'(db[1]); op_c.clr = 1'b1; end
      5'd11: begin op_a = MUL_W'(cb[1]); op_b = MUL_W'(db[0]); op_c.neg = 1'b1;
                   op_c.dst = DST_N2Z; end
      5'd12: begin op_a = hi_part(n1[0]); op_b = MUL_W'(dc[0]); op_c.clr = 1'b1;
                   op_c.sh = 1'b1; end
      5'd13: begin op_a = lo_part(n1[0]); op_b = MUL_W'(dc[0]); end
      5'd14: begin op_a = hi_part(n1[1]); op_b = MUL_W'(dc[1]); op_c.sh = 1'b1; end
      5'd15: begin op_a = lo_part(n1[1]); op_b = MUL_W'(dc[1]); end
      5'd16: begin op_a = hi_part(n1[2]); op_b = MUL_W'(dc[2]); op_c.sh = 1'b1; end
      5'd17: begin op_a = lo_part(n1[2]); op_b = MUL_W'(dc[2]); op_c.dst = DST_DIR; end
      5'd18: begin op_a = red(n1[1]); op_b = red(n2[2]); op_c.clr = 1'b1; end
      5'd19: begin op_a = red(n1[2]); op_b = red(n2[1]); op_c.neg = 1'b1;
                   op_c.dst = DST_PQX; end
      5'd20: begin op_a = red(n1[2]); op_b = red(n2[0]); op_c.clr = 1'b1; end
      5'd21: begin op_a = red(n1[0]); op_b = red(n2[2]); op_c.neg = 1'b1;
                   op_c.dst = DST_PQY; end
      5'd22: begin op_a = red(n1[0]); op_b = red(n2[1]); op_c.clr = 1'b1; end
      5'd23: begin op_a = red(n1[1]); op_b = red(n2[0]); op_c.neg = 1'b1;
                   op_c.dst = DST_PQZ; end
      5'd24: begin op_a = MUL_W'(pq[0]); op_b = MUL_W'(pq[0]); op_c.clr = 1'b1; end
      5'd25: begin op_a = MUL_W'(pq[1]); op_b = MUL_W'(pq[1]); end
      5'd26: begin op_a = MUL_W'(pq[2]); op_b = MUL_W'(pq[2]); op_c.dst = DST_SQ; end
      5'd27: begin op_a = red(n1[0]); op_b = red(n2[0]); op_c.clr = 1'b1; end
      5'd28: begin op_a = red(n1[1]); op_b = red(n2[1]); end
      5'd29: begin op_a = red(n1[2]); op_b = red(n2[2]); op_c.dst = DST_XD; end
      default: ;
    endcase
    op_c.vld = issue;
  end

  assign term     = ctl.sh ? (ACC_W'(prod) <<< SPL) : ACC_W'(prod);
  assign base     = ctl.clr ? '0 : acc;
  assign acc_next = ctl.neg ? base - term : base + term;

  assign shift1 = (m1[NORM_W-1:RED_W-1] != '0);
  assign shift2 = (m2[NORM_W-1:RED_W-1] != '0);

  assign rem_sh  = {rem, sq[SQ_W-1:SQ_W-2]};
  assign trial   = {2'b00, root, 2'b01};
  assign root_ge = (rem_sh >= trial);

  assign xs      = cx >>> iter;
  assign ys      = cy >>> iter;
  assign at_step = $signed(Z_W'(dau_pkg::atan_q16(iter)));

  always_comb begin
    if (cz[Z_W-1]) begin
      zc = '0;
    end else if (cz > Z180) begin
      zc = Z180[Z_W-3:0];
    end else begin
      zc = cz[Z_W-3:0];
    end
    zr  = {1'b0, zc} + (Z_W-1)'(128);
    rnd = ANG_W'(zr[Z_W-2:8]);
    if (deg) begin
      angle = '0;
    end else if (dir_neg) begin
      angle = FULL_TURN - rnd;
    end else begin
      angle = rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      step      <= '0;
      iter      <= '0;
      ctl       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      ctl <= op_c;
      if (state == B_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            step  <= '0;
            state <= B_NORM;
          end
        end
        B_NORM: begin
          if (issue) step <= step + 5'd1;
          else state <= B_DIR;
        end
        B_DIR: begin
          if (issue) step <= step + 5'd1;
          else state <= B_MAG;
        end
        B_MAG: begin
          if ((n1[0] == '0 && n1[1] == '0 && n1[2] == '0) ||
              (n2[0] == '0 && n2[1] == '0 && n2[2] == '0)) begin
            state <= B_DONE;
          end else begin
            state <= B_RED;
          end
        end
        B_RED: begin
          if (!shift1 && !shift2) begin
            state <= B_PQ;
          end
        end
        B_PQ: begin
          if (issue) step <= step + 5'd1;
          else state <= B_DOT;
        end
        B_DOT: begin
          if (issue) begin
            step <= step + 5'd1;
          end else begin
            iter  <= '0;
            state <= B_SQRT;
          end
        end
        B_SQRT: begin
          iter <= iter + 5'd1;
          if (iter == SQRT_LAST) begin
            state <= B_SETUP;
          end
        end
        B_SETUP: begin
          iter  <= '0;
          state <= B_CORD;
        end
        B_CORD: begin
          iter <= iter + 5'd1;
          if (iter == CORD_LAST) begin
            state <= B_DONE;
          end
        end
        B_DONE: begin
          if (out_free) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (ctl.vld) begin
      acc <= acc_next;
      case (ctl.dst)
        DST_N1X: n1[0] <= acc_next[NORM_W-1:0];
        DST_N1Y: n1[1] <= acc_next[NORM_W-1:0];
        DST_N1Z: n1[2] <= acc_next[NORM_W-1:0];
        DST_N2X: n2[0] <= acc_next[NORM_W-1:0];
        DST_N2Y: n2[1] <= acc_next[NORM_W-1:0];
        DST_N2Z: n2[2] <= acc_next[NORM_W-1:0];
        DST_PQX: pq[0] <= acc_next[PQ_W-1:0];
        DST_PQY: pq[1] <= acc_next[PQ_W-1:0];
        DST_PQZ: pq[2] <= acc_next[PQ_W-1:0];
        DST_SQ:  sq    <= acc_next[SQ_W-1:0];
        DST_XD:  xd    <= acc_next[XD_W-1:0];
        DST_DIR: dir_neg <= acc_next[ACC_W-1];
        default: ;
      endcase
    end

    if (state == B_IDLE && q_valid) begin
      ba[0] <= dsub(q_data.b.x, q_data.a.x);
      ba[1] <= dsub(q_data.b.y, q_data.a.y);
      ba[2] <= dsub(q_data.b.z, q_data.a.z);
      ca[0] <= dsub(q_data.c.x, q_data.a.x);
      ca[1] <= dsub(q_data.c.y, q_data.a.y);
      ca[2] <= dsub(q_data.c.z, q_data.a.z);
      cb[0] <= dsub(q_data.c.x, q_data.b.x);
      cb[1] <= dsub(q_data.c.y, q_data.b.y);
      cb[2] <= dsub(q_data.c.z, q_data.b.z);
      db[0] <= dsub(q_data.d.x, q_data.b.x);
      db[1] <= dsub(q_data.d.y, q_data.b.y);
      db[2] <= dsub(q_data.d.z, q_data.b.z);
      dc[0] <= dsub(q_data.d.x, q_data.c.x);
      dc[1] <= dsub(q_data.d.y, q_data.c.y);
      dc[2] <= dsub(q_data.d.z, q_data.c.z);
    end

    if (state == B_MAG) begin
      deg <= (n1[0] == '0 && n1[1] == '0 && n1[2] == '0) ||
             (n2[0] == '0 && n2[1] == '0 && n2[2] == '0);
      // The OR of the magnitudes has the same leading one as their maximum.
      m1 <= nmag(n1[0]) | nmag(n1[1]) | nmag(n1[2]);
      m2 <= nmag(n2[0]) | nmag(n2[1]) | nmag(n2[2]);
    end

    if (state == B_RED) begin
      if (shift1) begin
        m1    <= m1 >> 1;
        n1[0] <= n1[0] >>> 1;
        n1[1] <= n1[1] >>> 1;
        n1[2] <= n1[2] >>> 1;
      end
      if (shift2) begin
        m2    <= m2 >> 1;
        n2[0] <= n2[0] >>> 1;
        n2[1] <= n2[1] >>> 1;
        n2[2] <= n2[2] >>> 1;
      end
    end

    if (state == B_DOT && !issue) begin
      rem  <= '0;
      root <= '0;
    end

    if (state == B_SQRT) begin
      sq   <= sq << 2;
      root <= {root[ROOT_W-2:0], root_ge};
      rem  <= root_ge ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
    end

    if (state == B_SETUP) begin
      if (xd[XD_W-1]) begin
        cx <= CV_W'(root);
        cy <= -(CV_W'(xd));
        cz <= Z90;
      end else begin
        cx <= CV_W'(xd);
        cy <= CV_W'(root);
        cz <= '0;
      end
    end

    if (state == B_CORD) begin
      if (!cy[CV_W-1]) begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + at_step;
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - at_step;
      end
    end

    if (state == B_DONE && out_free) begin
      rsp.angle_deg  <= angle;
      rsp.degenerate <= deg;
    end
  end

endmodule

### rtl/dihedral_angle_unit.sv
// Top level of the dihedral angle unit: front end, query queue and back end.
//
// The unit holds a table of 1024 atoms, each with signed Q13.10 x, y and z.
// A load request (cmd 0) writes one entry in the cycle it is accepted and
// gives no response; a query request (cmd 1) names atoms A, B, C and D and
// gives one response: the dihedral angle between planes ABC and BCD as
// unsigned Q9.8 degrees from 0 to 360, or the degenerate flag with angle 0
// when either plane normal has zero length. Entries are not cleared by
// reset, and a query must only name entries that have been loaded. The
// front end takes a load every cycle while it is idle; a query keeps it
// busy while it reads its four atoms through the single read port of the
// table, then hands the atoms to a two-entry queue. The back end works on
// one query at a time: 30 products through one shared 34 by 34 bit
// multiplier and accumulator, one-bit normalizing shifts of the two
// normals, a bit-serial square root and 20 CORDIC rotations. Sustained
// query rate is set by the back end; a degenerate query returns early,
// right after the normals and the direction sign. Results leave through
// an output register, so the back end can work on the next query while a
// response waits, holding its result until the response is taken.
module dihedral_angle_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  dau_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output dau_pkg::rsp_t  rsp
);

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_valid;
  dau_pkg::query_t q_in;
  dau_pkg::query_t q_out;

  // Front end: owns the atom table and gathers each query's coordinates,
  // so a later load can never change a query that is already queued.
  dau_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .q_push    (q_push),
    .q_entry   (q_in),
    .q_full    (q_full)
  );

  dau_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  // Back end: computes the angle and drives the response register.
  dau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

`ifndef SYNTHESIS
  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.degenerate |-> rsp.angle_deg == '0)
    else $error("degenerate response with nonzero angle");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.angle_deg <= 17'd92160)
    else $error("angle beyond a full turn");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("waiting response dropped or changed");
`endif

endmodule
